// ----- hdl/subcnt_pkg.sv -----
// Package: shared types and constants for the substring occurrence counter.
`default_nettype none
package subcnt_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;
  localparam int BLOCK_W    = 3;

  // Register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_LENGTH  = 2'd1;
  localparam logic [1:0] REG_OVERLAP = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        match_here;
    logic [15:0] match_count;
    logic        text_done;
  } out_item_t;

  typedef struct packed {
    logic [63:0]      pattern_bytes;
    logic [LEN_W-1:0] pattern_length;
    logic             overlap_mode;
  } cfg_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic raw_hit;
    logic last;
  } cls_t;

endpackage
`default_nettype wire

// ----- hdl/subcnt_front.sv -----
// Front end: byte window, parallel pattern compare, classification.
`default_nettype none
module subcnt_front #(
  parameter int PATTERN_MAX = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   take,
  input  subcnt_pkg::in_item_t  item,
  input  subcnt_pkg::cfg_t      cfg,
  output subcnt_pkg::cls_t      cls
);
  import subcnt_pkg::*;

  localparam int WIN_W  = 8 * PATTERN_MAX;
  localparam int SEEN_W = $clog2(PATTERN_MAX + 1);

  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [PATTERN_MAX-1:0] eq_len;
  logic [PATTERN_MAX-1:0] sel_len;
  logic len_ok;
  logic have_enough;

  always_comb begin
    window_nxt[7:0] = item.text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_nxt[8*i +: 8] = window_r[8*(i-1) +: 8];
    end
    seen_nxt = (seen_r == SEEN_W'(PATTERN_MAX)) ? seen_r : seen_r + 1'b1;
  end

  // eq_len[L-1]: newest L bytes equal the first L pattern bytes
  always_comb begin
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      eq_len[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (cfg.pattern_bytes[8*k +: 8] != window_nxt[8*(l-1-k) +: 8]) begin
          eq_len[l-1] = 1'b0;
        end
      end
      sel_len[l-1] = (cfg.pattern_length == LEN_W'(l));
    end
  end

  assign len_ok      = (cfg.pattern_length != '0) &&
                       (cfg.pattern_length <= LEN_W'(PATTERN_MAX));
  assign have_enough = (LEN_W'(seen_nxt) >= cfg.pattern_length);

  assign cls.raw_hit = len_ok && have_enough && (|(eq_len & sel_len));
  assign cls.last    = item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        window_r <= '0;
        seen_r   <= '0;
      end else begin
        window_r <= window_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/subcnt_queue.sv -----
// Two-entry queue between front and back.
`default_nettype none
module subcnt_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  subcnt_pkg::cls_t  push_data,
  output logic              full,
  input  wire               pop,
  output logic              not_empty,
  output subcnt_pkg::cls_t  pop_data
);
  import subcnt_pkg::*;

  cls_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 2'd1;
    if (pop && !push) fill_nxt = fill_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/subcnt_back.sv -----
// Back end: blocking after a match, saturating count, output register.
`default_nettype none
module subcnt_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    avail,
  input  subcnt_pkg::cls_t       cls,
  input  subcnt_pkg::cfg_t       cfg,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output subcnt_pkg::out_item_t  out_data
);
  import subcnt_pkg::*;

  logic [BLOCK_W-1:0]     blocked_r, blocked_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   valid_r;
  out_item_t              data_r;
  logic                   hit;
  logic [31:0]            count_ext;

  assign pop = avail && (!valid_r || !out_stall);

  always_comb begin
    hit         = 1'b0;
    blocked_nxt = blocked_r;
    count_nxt   = count_r;
    if (blocked_r != '0) begin
      blocked_nxt = blocked_r - 1'b1;
    end else if (cls.raw_hit) begin
      hit = 1'b1;
      if (count_r != {COUNT_WIDTH{1'b1}}) count_nxt = count_r + 1'b1;
      if (!cfg.overlap_mode) begin
        blocked_nxt = BLOCK_W'(cfg.pattern_length - LEN_W'(1));
      end
    end
  end

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r <= '0;
      count_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        valid_r   <= 1'b1;
        blocked_r <= cls.last ? '0 : blocked_nxt;
        count_r   <= cls.last ? '0 : count_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r.match_here  <= hit;
      data_r.match_count <= count_ext[15:0];
      data_r.text_done   <= cls.last;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ----- hdl/substring_occurrence_counter_unit.sv -----
// Top level: substring occurrence counter with APB-style configuration.
//
// Counts occurrences of a 1..PATTERN_MAX byte pattern in a text that streams
// in one byte per transfer on the in_ channel (in_valid / in_stall). Every
// byte yields one result transfer on the out_ channel: match_here, the
// running saturating count and text_done, which copies last_byte. After the
// result for the last byte all per-text state clears.
// The front compare is combinational: an accepted byte's result is written into
// a queue slot, and the back end then pops it into the output register.
// Throughput: one byte per cycle while in_stall is low; the window compare
// is fully parallel and the count update is a single add and compare.
// A two-entry queue sits between the front (window + compare) and the back
// (match blocking, count, output register). When the receiver holds
// out_stall, the result register holds, the queue fills, and in_stall rises
// once both queue entries are taken: three results in flight at most.
// Reset (rst_n low, synchronous) empties queue and output, clears window
// and count, and sets pattern 0, length 1, overlap off.
// Registers at byte address 8*i: pattern_bytes, pattern_length,
// overlap_mode; write them only while no text byte is in flight.
`default_nettype none
module substring_occurrence_counter_unit #(
  parameter int PATTERN_MAX = subcnt_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = subcnt_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  subcnt_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output subcnt_pkg::out_item_t                 out_data,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire [subcnt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire [subcnt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [subcnt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                  pready
);
  import subcnt_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;
  logic       take;
  cls_t       front_cls;
  cls_t       q_cls;
  logic       q_full;
  logic       q_avail;
  logic       q_pop;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.overlap_mode   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN: cfg_r.pattern_bytes  <= pwdata;
        REG_LENGTH:  cfg_r.pattern_length <= pwdata[LEN_W-1:0];
        REG_OVERLAP: cfg_r.overlap_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN: prdata = cfg_r.pattern_bytes;
      REG_LENGTH:  prdata = CFG_DATA_W'(cfg_r.pattern_length);
      REG_OVERLAP: prdata = CFG_DATA_W'(cfg_r.overlap_mode);
      default:     prdata = '0;
    endcase
  end

  // Input transfer whenever the queue has room
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  subcnt_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .cfg   (cfg_r),
    .cls   (front_cls)
  );

  subcnt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .pop_data  (q_cls)
  );

  subcnt_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (q_avail),
    .cls       (q_cls),
    .cfg       (cfg_r),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hdl/subcnt_checker.sv -----
// Port-level checker for the substring occurrence counter, with its bind.
`default_nettype none
module subcnt_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input subcnt_pkg::out_item_t  out_data
);
  import subcnt_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // With no result pending the queue cannot be full
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Every accepted byte is followed by a valid result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

endmodule

bind substring_occurrence_counter_unit subcnt_checker u_subcnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the substring occurrence counter: directed rows, random texts, self-checked.
//
// A directed script comes first. Its byte rows are checked against values
// written into the script where they are obvious. The remaining rows and
// the random texts are checked against an in-bench scan model.
// Register writes go over the APB-style port, and only
// while nothing is in flight. Both channels idle at random. The receiver
// takes one long hold-off so that the block backs up and stalls the input.
`default_nettype none
module tb;
  import subcnt_pkg::*;

  localparam int LIMIT_CYCLES  = 60_000;
  localparam int RANDOM_ITEMS  = 1060;
  localparam int HOLD_CYCLES   = 60;
  localparam int IDLE_PCT      = 11;

  typedef enum logic {STEP_BYTE, STEP_WRITE} row_kind_t;

  // One script row: a text byte (value[7:0], last) or a register write.
  // typed rows carry their expected result in want.
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_idx;
    logic [63:0] value;
    logic       last;
    logic       typed;
    out_item_t  want;
  } row_t;

  localparam out_item_t NO_WANT = '0;

  localparam row_t DIRECTED_ROWS [32] = '{
    // reset values: pattern 0x00, length 1, no overlap
    '{STEP_BYTE,  REG_PATTERN, 64'h00, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b0}},
    '{STEP_BYTE,  REG_PATTERN, 64'hFF, 1'b0, 1'b1, '{1'b0, 16'd1, 1'b0}},
    '{STEP_BYTE,  REG_PATTERN, 64'h00, 1'b1, 1'b1, '{1'b1, 16'd2, 1'b1}},
    // "aba", skip mode, on "ababa": second alignment is blocked
    '{STEP_WRITE, REG_PATTERN, 64'h61_6261, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, REG_LENGTH,  64'd3, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h62, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h62, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b1, 1'b0, NO_WANT},
    // same text with overlap: both alignments count
    '{STEP_WRITE, REG_OVERLAP, 64'd1, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h62, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h62, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b1, 1'b0, NO_WANT},
    // length out of range never matches
    '{STEP_WRITE, REG_LENGTH,  64'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1}},
    '{STEP_WRITE, REG_LENGTH,  64'd15, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1}},
    // full-length all-ones pattern, text shorter than the pattern
    '{STEP_WRITE, REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, REG_LENGTH,  64'd8, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'hFF, 1'b0, 1'b1, '{1'b0, 16'd0, 1'b0}},
    '{STEP_BYTE,  REG_PATTERN, 64'hFF, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b1}},
    // "aa" in skip mode, overlap switched on mid-text: pending block still runs out
    '{STEP_WRITE, REG_PATTERN, 64'h6161, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, REG_LENGTH,  64'd2, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, REG_OVERLAP, 64'd0, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_WRITE, REG_OVERLAP, 64'd1, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b0, 1'b0, NO_WANT},
    '{STEP_BYTE,  REG_PATTERN, 64'h61, 1'b1, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic       pready;

  // Scan model: copy of the registers and the per-text state.
  logic [63:0] cfg_pattern = '0;
  logic [3:0]  cfg_len = 4'd1;
  logic        cfg_overlap = 1'b0;
  logic [63:0] text_window = '0;
  int          text_len_seen = 0;
  logic [2:0]  skip_left = '0;
  logic [15:0] hits_so_far = '0;

  out_item_t pending_results [$];
  int        errors = 0;
  int        cycles = 0;

  // Idle control shared with the receiver process.
  bit quiet = 1'b0;   // no random idling while set
  int hold_req = 0;   // each increment asks the receiver for one long hold-off

  substring_occurrence_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One byte through the scan model; updates the model state.
  function automatic out_item_t scan_byte(in_item_t it);
    out_item_t r;
    logic      found;
    int        n;
    int        k;
    n = int'(cfg_len);
    text_window = {text_window[55:0], it.text_byte};
    if (text_len_seen < 8) text_len_seen++;
    found = 1'b0;
    if (skip_left != 0) begin
      skip_left--;
    end else begin
      found = (n >= 1 && n <= 8 && text_len_seen >= n);
      // pattern byte k must sit n-1-k bytes back in the window
      for (k = 0; k < 8; k++)
        if (found && k < n && cfg_pattern[8*k +: 8] != text_window[8*(n-1-k) +: 8])
          found = 1'b0;
      if (found) begin
        if (hits_so_far != '1) hits_so_far++;
        if (!cfg_overlap) skip_left = 3'(n - 1);
      end
    end
    r.match_here  = found;
    r.match_count = hits_so_far;
    r.text_done   = it.last_byte;
    if (it.last_byte) begin
      text_window   = '0;
      text_len_seen = 0;
      skip_left     = '0;
      hits_so_far   = '0;
    end
    return r;
  endfunction

  // Offer one byte, wait for the transfer, queue its expected result.
  task automatic send_byte(in_item_t it, bit typed, out_item_t want);
    out_item_t model_out;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    model_out = scan_byte(it);
    pending_results.push_back(typed ? want : model_out);
  endtask

  // Stop offering and wait until every expected result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then the bus returns to idle.
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PATTERN: cfg_pattern = value;
      REG_LENGTH:  cfg_len = value[3:0];
      REG_OVERLAP: cfg_overlap = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.match_here !== want.match_here) begin
          $display("%0t: match_here expected %0d got %0d", $time, want.match_here,
                   out_data.match_here);
          errors++;
        end
        if (out_data.match_count !== want.match_count) begin
          $display("%0t: match_count expected %0d got %0d", $time, want.match_count,
                   out_data.match_count);
          errors++;
        end
        if (out_data.text_done !== want.text_done) begin
          $display("%0t: text_done expected %0d got %0d", $time, want.text_done,
                   out_data.text_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] text_bytes [$];
    int         random_sent;
    int         phase;
    int         n_texts;
    int         text_len;
    int         cut;
    int         lim;
    int         pick;
    int         k;
    int         i;
    int         t;
    logic [3:0] len;
    logic [63:0] pat;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script.
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == STEP_WRITE) begin
        drain();
        write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
      end else begin
        send_byte(in_item_t'{DIRECTED_ROWS[r].value[7:0], DIRECTED_ROWS[r].last},
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    // Random phases: a fresh setting, then a few texts built around the pattern.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      // lengths 1 and 8 first, then mostly legal lengths, a few out of range
      if (phase == 0) len = 4'd1;
      else if (phase == 1) len = 4'd8;
      else if ($urandom_range(9) == 0) len = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
      else len = 4'($urandom_range(8, 1));
      pick = $urandom_range(9);
      if (pick == 0) pat = '1;
      else if (pick == 1) pat = '0;
      else if (pick <= 4) pat = {$urandom, $urandom};
      else
        for (k = 0; k < 8; k++) pat[8*k +: 8] = 8'h41 + 8'($urandom_range(1));
      write_reg(REG_PATTERN, pat);
      write_reg(REG_LENGTH, 64'(len));
      write_reg(REG_OVERLAP, 64'($urandom_range(1)));

      quiet = (phase == 8 || phase == 9);
      if (phase == 4) hold_req++;

      lim = (cfg_len >= 1 && cfg_len <= 8) ? int'(cfg_len) : 8;
      n_texts = $urandom_range(6, 3);
      for (t = 0; t < n_texts; t++) begin
        text_bytes.delete();
        text_len = $urandom_range(30, 1);
        while (text_bytes.size() < text_len) begin
          pick = $urandom_range(99);
          if (pick < 25 && cfg_len >= 1 && cfg_len <= 8)
            for (k = 0; k < int'(cfg_len); k++) text_bytes.push_back(cfg_pattern[8*k +: 8]);
          else if (pick < 40)
            text_bytes.push_back(8'($urandom_range(255)));
          else
            text_bytes.push_back(cfg_pattern[8*$urandom_range(lim - 1) +: 8]);
        end
        // now and then retune in the middle of a text, with the block drained
        cut = ($urandom_range(7) == 0) ? text_bytes.size() / 2 : -1;
        for (i = 0; i < text_bytes.size(); i++) begin
          if (i == cut && i > 0) begin
            drain();
            if ($urandom_range(1)) write_reg(REG_OVERLAP, 64'(!cfg_overlap));
            else write_reg(REG_LENGTH, 64'($urandom_range(8, 1)));
          end
          send_byte(in_item_t'{text_bytes[i], i == text_bytes.size() - 1}, 1'b0, NO_WANT);
          random_sent++;
        end
      end
      phase++;
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/subcnt_pkg.sv
hdl/subcnt_front.sv
hdl/subcnt_queue.sv
hdl/subcnt_back.sv
hdl/substring_occurrence_counter_unit.sv
hdl/subcnt_checker.sv
tb/tb.sv
